@@ rtl/rac_pkg.sv @@
// ----------------------------------------------------------------------------
// rac_pkg
// Shared widths, limits and register indexes for the ray/box closest-hit block.
// ----------------------------------------------------------------------------
package rac_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ID_BITS    = 16;
  localparam int DIST_BITS  = COORD_BITS - 1;
  localparam int NUM_BITS   = COORD_BITS + 1;
  localparam int DVD_BITS   = NUM_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(DVD_BITS + 1);
  localparam int IDX_BITS   = 3;

  localparam logic signed [COORD_BITS-1:0] T_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] T_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_DIR_X    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_DIR_Z    = 3'd5;

  // Divider request from the sequencer.
  typedef struct packed {
    logic                       start;
    logic signed [NUM_BITS-1:0] num;
    logic signed [COORD_BITS-1:0] den;
  } div_req_t;

endpackage

@@ rtl/ray_aabb_closest_hit.sv @@
// ----------------------------------------------------------------------------
// ray_aabb_closest_hit
// Ray versus axis-aligned box slab test with nearest-hit tracking.
// ----------------------------------------------------------------------------
// One box item at a time is taken. A disabled box goes straight to the finish
// state. An enabled box runs each axis in turn: an axis with a zero direction
// is only checked against its slab, otherwise two divisions run on the shared
// bit-serial divider and a further step folds in the slab bounds; a box that
// misses on an early axis stops there.
// The result of the last box sits in an output register, so the next query
// can start while it waits to be taken.
module ray_aabb_closest_hit
  import rac_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [IDX_BITS-1:0]          cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_min_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  input  logic [ID_BITS-1:0]           node_id,
  input  logic                         box_enabled,
  input  logic                         last_box,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit_found,
  output logic [ID_BITS-1:0]           hit_node,
  output logic [DIST_BITS-1:0]         hit_distance
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_DIV0   = 6'b000100,
    S_DIV1   = 6'b001000,
    S_UPDATE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic signed [COORD_BITS-1:0] origin [3];
  logic signed [COORD_BITS-1:0] dir [3];
  logic signed [COORD_BITS-1:0] lo [3];
  logic signed [COORD_BITS-1:0] hi [3];
  logic [ID_BITS-1:0]           node;
  logic                         enabled;
  logic                         last;
  logic [1:0]                   axis;
  logic                         miss;
  logic signed [COORD_BITS-1:0] tmin;
  logic signed [COORD_BITS-1:0] tmax;
  logic signed [COORD_BITS-1:0] t0;
  logic [DIST_BITS-1:0]         best_distance;
  logic [ID_BITS-1:0]           best_node;
  logic                         any_hit;

  logic signed [COORD_BITS-1:0] o_a, d_a, lo_a, hi_a;
  logic signed [COORD_BITS-1:0] t0s, t1s, tmin_next, tmax_next;
  logic signed [COORD_BITS-1:0] div_quot;
  logic                         div_done;
  div_req_t                     div_req;
  logic                         take;
  logic                         any_next;
  logic                         out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        dir[i]    <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin[0] <= cfg_data;
        REG_ORIGIN_Y: origin[1] <= cfg_data;
        REG_ORIGIN_Z: origin[2] <= cfg_data;
        REG_DIR_X:    dir[0]    <= cfg_data;
        REG_DIR_Y:    dir[1]    <= cfg_data;
        REG_DIR_Z:    dir[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-axis operand selection.
  always_comb begin
    case (axis)
      2'd0: begin
        o_a = origin[0]; d_a = dir[0]; lo_a = lo[0]; hi_a = hi[0];
      end
      2'd1: begin
        o_a = origin[1]; d_a = dir[1]; lo_a = lo[1]; hi_a = hi[1];
      end
      default: begin
        o_a = origin[2]; d_a = dir[2]; lo_a = lo[2]; hi_a = hi[2];
      end
    endcase
  end

  // Divider requests: the min bound on entering, the max bound after it.
  always_comb begin
    div_req.den   = d_a;
    div_req.start = 1'b0;
    div_req.num   = NUM_BITS'(lo_a) - NUM_BITS'(o_a);
    if (state == S_CHECK && d_a != '0) begin
      div_req.start = 1'b1;
    end else if (state == S_DIV0 && div_done) begin
      div_req.start = 1'b1;
      div_req.num   = NUM_BITS'(hi_a) - NUM_BITS'(o_a);
    end
  end

  rac_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // Slab interval update; div_quot holds t1 while in S_UPDATE.
  assign t0s       = d_a[COORD_BITS-1] ? div_quot : t0;
  assign t1s       = d_a[COORD_BITS-1] ? t0 : div_quot;
  assign tmin_next = (t0s > tmin) ? t0s : tmin;
  assign tmax_next = (t1s < tmax) ? t1s : tmax;

  // Nearest-hit bookkeeping for the box at hand.
  assign take     = !miss && (!any_hit || tmin[DIST_BITS-1:0] < best_distance);
  assign any_next = any_hit || take;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      axis          <= '0;
      miss          <= 1'b0;
      any_hit       <= 1'b0;
      best_node     <= '0;
      best_distance <= '1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            axis  <= '0;
            miss  <= !box_enabled;
            state <= box_enabled ? S_CHECK : S_FINISH;
          end
        end
        S_CHECK: begin
          if (d_a == '0) begin
            if (o_a < lo_a || o_a > hi_a) begin
              miss  <= 1'b1;
              state <= S_FINISH;
            end else if (axis == 2'd2) begin
              state <= S_FINISH;
            end else begin
              axis <= axis + 2'd1;
            end
          end else begin
            state <= S_DIV0;
          end
        end
        S_DIV0: begin
          if (div_done) begin
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (tmax_next < tmin_next) begin
            miss  <= 1'b1;
            state <= S_FINISH;
          end else if (axis == 2'd2) begin
            state <= S_FINISH;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (!last) begin
            if (take) begin
              any_hit       <= 1'b1;
              best_node     <= node;
              best_distance <= tmin[DIST_BITS-1:0];
            end
            state <= S_IDLE;
          end else if (out_free) begin
            any_hit       <= 1'b0;
            best_node     <= '0;
            best_distance <= '1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result valid: set when a query closes, cleared when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && last && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Box capture and slab interval registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      lo[0]   <= box_min_x;
      lo[1]   <= box_min_y;
      lo[2]   <= box_min_z;
      hi[0]   <= box_max_x;
      hi[1]   <= box_max_y;
      hi[2]   <= box_max_z;
      node    <= node_id;
      enabled <= box_enabled;
      last    <= last_box;
      tmin    <= '0;
      tmax    <= T_MAX;
    end else if (state == S_DIV0 && div_done) begin
      t0 <= div_quot;
    end else if (state == S_UPDATE) begin
      tmin <= tmin_next;
      tmax <= tmax_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && last && out_free) begin
      hit_found    <= any_next;
      hit_node     <= take ? node : best_node;
      hit_distance <= take ? tmin[DIST_BITS-1:0] : (any_hit ? best_distance : '0);
    end
  end

  property p_empty_result;
    @(posedge clk) disable iff (rst)
      out_valid && !hit_found |-> hit_node == '0 && hit_distance == '0;
  endproperty
  a_empty_result: assert property (p_empty_result) else $error("miss result not zero");

  property p_div_done_state;
    @(posedge clk) disable iff (rst) div_done |-> state == S_DIV0 || state == S_DIV1;
  endproperty
  a_div_done_state: assert property (p_div_done_state) else $error("stray divider done");

  property p_clear_node;
    @(posedge clk) disable iff (rst) !any_hit |-> best_node == '0;
  endproperty
  a_clear_node: assert property (p_clear_node) else $error("node kept without hit");

  property p_disabled_misses;
    @(posedge clk) disable iff (rst) state == S_FINISH && !enabled |-> miss;
  endproperty
  a_disabled_misses: assert property (p_disabled_misses) else $error("disabled box tested");

endmodule

@@ rtl/rac_div.sv @@
// ----------------------------------------------------------------------------
// rac_div
// Iterative restoring divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero and saturated to the signed coordinate range. One quotient bit a cycle.
// ----------------------------------------------------------------------------
module rac_div
  import rac_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  div_req_t                     req,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] quot
);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [DVD_BITS-1:0]   dvd;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] dmag;
  logic                  neg;
  logic [NUM_BITS-1:0]   nmag;
  logic [NUM_BITS-1:0]   dnegv;
  logic [NUM_BITS-1:0]   rem_sh;
  logic [NUM_BITS-1:0]   rem_sub;
  logic                  ge;
  logic                  sat;

  // Operand magnitudes.
  assign nmag   = req.num[NUM_BITS-1] ? NUM_BITS'(-req.num) : NUM_BITS'(req.num);
  assign dnegv  = {1'b0, dmag};
  assign rem_sh = {rem, dvd[DVD_BITS-1]};
  assign ge     = rem_sh >= dnegv;
  assign rem_sub = rem_sh - dnegv;

  // One shift-and-subtract step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DVD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= {nmag, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      dmag <= req.den[COORD_BITS-1] ? COORD_BITS'(-req.den) : COORD_BITS'(req.den);
      neg  <= req.num[NUM_BITS-1] ^ req.den[COORD_BITS-1];
    end else if (busy) begin
      rem <= ge ? rem_sub[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
      dvd <= {dvd[DVD_BITS-2:0], ge};
    end
  end

  // Saturate and apply the sign.
  assign sat = |dvd[DVD_BITS-1:COORD_BITS-1];

  always_comb begin
    if (neg) begin
      quot = sat ? T_MIN : -$signed(dvd[COORD_BITS-1:0]);
    end else begin
      quot = sat ? T_MAX : $signed(dvd[COORD_BITS-1:0]);
    end
  end

  property p_no_restart;
    @(posedge clk) disable iff (rst) req.start |-> !busy;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

  property p_done_single;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_single: assert property (p_done_single) else $error("done held two cycles");

endmodule

@@ tb/ray_aabb_closest_hit_tb.sv @@
// ----------------------------------------------------------------------------
// ray_aabb_closest_hit_tb
// Self-checking bench for the ray/box closest-hit block. Queries of boxes are
// streamed in under several ray settings. Each box is run through a bench-side
// slab-test model when it is taken, and each query result is checked field by
// field against the model.
// ----------------------------------------------------------------------------
module ray_aabb_closest_hit_tb;
  import rac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_LIM   = 64'sd1 << (COORD_BITS - 1);
  localparam longint CYCLE_CAP = 2000000;
  localparam int     DRAIN     = 400;

  typedef bit bool_t;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] lo;
    logic [2:0][COORD_BITS-1:0] hi;
    logic [ID_BITS-1:0]         node;
    logic                       en;
    logic                       last;
  } box_item_t;

  typedef struct packed {
    logic                 found;
    logic [ID_BITS-1:0]   node;
    logic [DIST_BITS-1:0] hit_dist;
  } hit_result_t;

  logic clk, rst;
  logic cfg_we;
  logic [IDX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [COORD_BITS-1:0] box_min_x, box_min_y, box_min_z;
  logic signed [COORD_BITS-1:0] box_max_x, box_max_y, box_max_z;
  logic [ID_BITS-1:0] node_id;
  logic box_enabled, last_box;
  logic hit_found;
  logic [ID_BITS-1:0] hit_node;
  logic [DIST_BITS-1:0] hit_distance;

  ray_aabb_closest_hit dut (.*);

  // Bench copy of the ray and of the running nearest hit.
  logic [COORD_BITS-1:0] ray_org [3];
  logic [COORD_BITS-1:0] ray_dir [3];
  logic [DIST_BITS-1:0]  near_dist;
  logic [ID_BITS-1:0]    near_node;
  logic                  near_any;

  box_item_t   pending_boxes[$];
  hit_result_t expected_hits[$];
  int  sent_n, taken_n, checked_n, errors, gap, stall_left;
  bool_t quiet, stall_done;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0h, expected %0h", checked_n, what, got, want);
    errors++;
  endtask

  // Saturating fixed-point quotient (num << FRAC_BITS) / den, truncated.
  function automatic longint slab_quot(input longint num, input longint den);
    bit neg, sat;
    longint unsigned n, d, q, r;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    sat = q > SAT_LIM;
    for (int i = 0; i < FRAC_BITS && !sat; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
      if (q > SAT_LIM) sat = 1;
    end
    if (neg) return (sat || q >= SAT_LIM) ? -SAT_LIM : -longint'(q);
    return (sat || q > SAT_LIM - 1) ? SAT_LIM - 1 : longint'(q);
  endfunction

  // Slab test of one box against the current ray; entry gets tmin on a hit.
  function automatic bit slab_hit(input box_item_t b, output longint entry);
    longint tmin, tmax, o, d, lo, hi, t0, t1, s;
    tmin = 0;
    tmax = SAT_LIM - 1;
    entry = 0;
    for (int a = 0; a < 3; a++) begin
      o  = longint'($signed(ray_org[a]));
      d  = longint'($signed(ray_dir[a]));
      lo = longint'($signed(b.lo[a]));
      hi = longint'($signed(b.hi[a]));
      if (d == 0) begin
        if (o < lo || o > hi) return 0;
        continue;
      end
      t0 = slab_quot(lo - o, d);
      t1 = slab_quot(hi - o, d);
      if (d < 0) begin
        s = t0;
        t0 = t1;
        t1 = s;
      end
      if (t0 > tmin) tmin = t0;
      if (t1 < tmax) tmax = t1;
      if (tmax < tmin) return 0;
    end
    entry = tmin;
    return 1;
  endfunction

  // Fold one taken box into the running nearest hit; close the query on last.
  task automatic track_nearest(input box_item_t b);
    longint t;
    hit_result_t r;
    if (b.en && slab_hit(b, t)) begin
      if (!near_any || t[DIST_BITS-1:0] < near_dist) begin
        near_dist = t[DIST_BITS-1:0];
        near_node = b.node;
        near_any  = 1'b1;
      end
    end
    if (b.last) begin
      r.found    = near_any;
      r.node     = near_any ? near_node : '0;
      r.hit_dist = near_any ? near_dist : '0;
      expected_hits.push_back(r);
      near_dist = '1;
      near_node = '0;
      near_any  = 1'b0;
    end
  endtask

  // Input handshake, result check and cycle limit, all at the rising edge.
  always @(posedge clk) begin
    hit_result_t want;
    box_item_t b;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst && in_valid && in_ready) begin
      b.lo = {box_min_z, box_min_y, box_min_x};
      b.hi = {box_max_z, box_max_y, box_max_x};
      b.node = node_id;
      b.en = box_enabled;
      b.last = last_box;
      track_nearest(b);
      taken_n++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result, node", hit_node, 0);
      end else begin
        want = expected_hits.pop_front();
        if (hit_found !== want.found) report_mismatch("hit_found", hit_found, want.found);
        if (hit_node !== want.node) report_mismatch("hit_node", hit_node, want.node);
        if (hit_distance !== want.hit_dist)
          report_mismatch("hit_distance", hit_distance, want.hit_dist);
      end
      checked_n++;
    end
  end

  // Box sender: holds each item until taken, with random idle bursts.
  always @(negedge clk) begin
    box_item_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken_n != sent_n) begin
      // Item still waiting to be taken.
    end else if (gap > 0) begin
      gap--;
      in_valid <= 1'b0;
    end else if (pending_boxes.size() != 0) begin
      b = pending_boxes.pop_front();
      {box_min_z, box_min_y, box_min_x} <= b.lo;
      {box_max_z, box_max_y, box_max_x} <= b.hi;
      node_id <= b.node;
      box_enabled <= b.en;
      last_box <= b.last;
      in_valid <= 1'b1;
      sent_n++;
      if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 8);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random stall bursts plus one long hold-off to back up the input.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!stall_done && checked_n >= 20) begin
      stall_done = 1;
      stall_left = 3000;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [COORD_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < REG_DIR_X) ray_org[idx[1:0]] = val;
    else ray_dir[2'(idx - REG_DIR_X)] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ray(input logic [COORD_BITS-1:0] ox, oy, oz, dx, dy, dz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
  endtask

  task automatic add_box(input logic [COORD_BITS-1:0] lx, ly, lz, hx, hy, hz,
                         input logic [ID_BITS-1:0] node, input logic en, last);
    box_item_t b;
    b.lo = {lz, ly, lx};
    b.hi = {hz, hy, hx};
    b.node = node;
    b.en = en;
    b.last = last;
    pending_boxes.push_back(b);
  endtask

  // Random queries: mostly small boxes around the origin, some inverted or full-range.
  task automatic add_queries(input int n_boxes);
    box_item_t b;
    int left, kind;
    logic signed [COORD_BITS-1:0] c, h;
    left = 0;
    for (int i = 0; i < n_boxes; i++) begin
      if (left == 0) left = $urandom_range(1, 8);
      kind = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        if (kind == 0) begin
          b.lo[a] = $urandom;
          b.hi[a] = $urandom;
        end else begin
          c = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          h = $urandom_range(0, 1 << 19);
          b.lo[a] = (kind == 1) ? c + h : c - h;
          b.hi[a] = (kind == 1) ? c - h : c + h;
        end
      end
      b.node = ID_BITS'($urandom);
      b.en = $urandom_range(0, 7) != 0;
      left--;
      b.last = (left == 0) || (i == n_boxes - 1);
      pending_boxes.push_back(b);
    end
  endtask

  task automatic drain_phase();
    wait (pending_boxes.size() == 0 && taken_n == sent_n && expected_hits.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    box_min_x = '0; box_min_y = '0; box_min_z = '0;
    box_max_x = '0; box_max_y = '0; box_max_z = '0;
    node_id = '0; box_enabled = 1'b0; last_box = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ray_org[a] = '0;
      ray_dir[a] = '0;
    end
    near_dist = '1; near_node = '0; near_any = 1'b0;
    sent_n = 0; taken_n = 0; checked_n = 0; errors = 0; gap = 0; stall_left = 0;
    quiet = 0; stall_done = 0; cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset ray has zero direction: every axis is parallel to its slab.
    add_box(-32'sd5, -32'sd5, -32'sd5, 32'sd5, 32'sd5, 32'sd5, 16'h0001, 1, 0);
    add_box(32'sd1, -32'sd5, -32'sd5, 32'sd5, 32'sd5, 32'sd5, 16'h0002, 1, 1);
    add_box(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'hffff, 1, 1);
    add_box(32'sd1, 32'sd1, 32'sd1, -32'sd1, -32'sd1, -32'sd1, 16'h0003, 1, 1);
    drain_phase();

    // Unit diagonal ray from the origin: directed corner cases.
    set_ray(0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
    add_box(32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000, 16'h0010, 1, 1);
    add_box(-32'sh20000, -32'sh20000, -32'sh20000, -32'sh10000, -32'sh10000, -32'sh10000,
            16'h0011, 1, 1);
    add_box(-32'sh10000, -32'sh10000, -32'sh10000, 32'h10000, 32'h10000, 32'h10000,
            16'h0000, 1, 1);
    // Equal distances keep the first; a disabled nearer box is ignored.
    add_box(32'h30000, 32'h30000, 32'h30000, 32'h40000, 32'h40000, 32'h40000, 16'h0020, 1, 0);
    add_box(32'h30000, 32'h30000, 32'h30000, 32'h50000, 32'h50000, 32'h50000, 16'h0021, 1, 0);
    add_box(32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000, 16'h0022, 0, 0);
    add_box(32'h20000, 32'h20000, 32'h20000, 32'h40000, 32'h40000, 32'h40000, 16'h0023, 1, 0);
    add_box(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 16'h0024, 0, 1);
    // Full-range corners saturate the quotients; largest distance still counts.
    add_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 16'hffff, 1, 1);
    add_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 16'h1234, 1, 0);
    add_box(32'h7ffffffe, 32'h7ffffffe, 32'h7ffffffe, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 16'h4321, 1, 1);
    add_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 16'haaaa, 1, 1);
    add_box(0, 0, 0, 0, 0, 0, 16'h5555, 0, 1);
    drain_phase();

    // Random queries under a series of rays, extremes included.
    add_queries(130);
    drain_phase();
    set_ray(32'hffff0000, 32'h00008000, 32'h00030000, 32'hffff0000, 32'h00000001,
            32'h00020000);
    add_queries(120);
    drain_phase();
    set_ray(32'h7fffffff, 32'h80000000, 32'h0, 32'h80000000, 32'h7fffffff, 32'h0);
    add_queries(100);
    drain_phase();
    set_ray($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
            $urandom, $urandom, $urandom);
    add_queries(120);
    drain_phase();
    set_ray(32'h00010000, 32'hfff00000, 32'h0, 32'hffffffff, 32'h00000100, 32'hfffc0000);
    add_queries(120);
    drain_phase();

    // Closing stretch runs at full rate on both sides.
    quiet = 1;
    set_ray(0, 0, 0, 32'h00008000, 32'hffff8000, 32'h00010000);
    add_queries(140);
    drain_phase();

    $display("covered %0d boxes over 7 ray settings and %0d query results", taken_n, checked_n);
    $display("including zero, saturating, inverted, disabled and tied boxes");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
